// ----- rtl/core/weighted_grid_astar_with_constraints_core_defines.svh -----
// Assertion macros shared by the grid search core.
`ifndef WEIGHTED_GRID_ASTAR_WITH_CONSTRAINTS_CORE_DEFINES_SVH
`define WEIGHTED_GRID_ASTAR_WITH_CONSTRAINTS_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Implication checked at every clock edge outside reset.
`define WGAC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Condition that must hold at every clock edge outside reset.
`define WGAC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);
`else
`define WGAC_ASSERT_IMPL(label, ante, cons, msg)
`define WGAC_ASSERT_ALWAYS(label, cond, msg)
`endif

`endif

// ----- rtl/core/wgac_pkg.sv -----
// Types and constants shared by the grid search core.
package wgac_pkg;

    // Item function codes.
    localparam logic [2:0] FuncWriteCell = 3'd0;
    localparam logic [2:0] FuncAddCon    = 3'd1;
    localparam logic [2:0] FuncClrCon    = 3'd2;
    localparam logic [2:0] FuncSearch    = 3'd3;
    localparam logic [2:0] FuncReadStep  = 3'd4;

    // Result status codes.
    localparam logic [1:0] StatusDone   = 2'd0;
    localparam logic [1:0] StatusNoPath = 2'd1;
    localparam logic [1:0] StatusBeyond = 2'd2;

    // Register indexes (byte address bits 3:2).
    localparam logic [1:0] RegWeight = 2'd0;
    localparam logic [1:0] RegRows   = 2'd1;
    localparam logic [1:0] RegCols   = 2'd2;

    // Neighbour directions.
    localparam logic [1:0] DirUp    = 2'd0;
    localparam logic [1:0] DirDown  = 2'd1;
    localparam logic [1:0] DirLeft  = 2'd2;
    localparam logic [1:0] DirRight = 2'd3;

    localparam int         PathLimit   = 256;
    localparam int         TimeHorizon = 64;
    localparam logic [8:0] CostNone    = 9'd511;

    typedef struct packed {
        logic [2:0] func;
        logic [3:0] cell_row;
        logic [3:0] cell_col;
        logic [3:0] goal_row;
        logic [3:0] goal_col;
        logic       cell_free;
        logic [5:0] time_step;
        logic [7:0] step_index;
    } wgac_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [8:0] path_length;
        logic [3:0] step_row;
        logic [3:0] step_col;
    } wgac_out_t;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_CON_WR,
        ST_INIT,
        ST_START,
        ST_SCAN,
        ST_PICK,
        ST_NB_RD,
        ST_NB_EV,
        ST_BLD,
        ST_BLD_W,
        ST_RD_W,
        ST_OUT
    } wgac_state_t;

endpackage

// ----- rtl/core/weighted_grid_astar_with_constraints_core.sv -----
// Search flow: a sweep that resets every node entry, then per expansion a scan over the
// node memory and a pick of the best open node, a relaxation of the neighbours, and at the
// goal a rebuild of the path by its predecessor chain. The scan over the node memory (one entry
// per cycle) sets the search time. One item is worked on at a time, and a waiting result
// holds the next item in its final cycle until the result is taken. Reset starts a clearing
// pass over the cell and constraint memories.
`include "weighted_grid_astar_with_constraints_core_defines.svh"

module weighted_grid_astar_with_constraints_core #(
    parameter int GRID_ROWS = 16,
    parameter int GRID_COLS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  wgac_pkg::wgac_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output wgac_pkg::wgac_out_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    import wgac_pkg::*;

    localparam int RW    = $clog2(GRID_ROWS);
    localparam int CW    = $clog2(GRID_COLS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = 1 << AW;
    localparam int HW    = $clog2(GRID_ROWS + GRID_COLS - 1);
    localparam int PW    = $clog2(16 * 511 + 255 * (GRID_ROWS + GRID_COLS - 2) + 1);
    localparam int PAW   = $clog2(PathLimit);

    typedef struct packed {
        logic          open;
        logic [8:0]    cost;
        logic [PW-1:0] prio;
        logic [AW-1:0] pred;
    } node_t;

    localparam int NW = $bits(node_t);

    // Control state.
    wgac_state_t   state_reg, state_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          boot_reg, boot_next;
    logic          pend_reg, pend_next;
    logic          have_reg, have_next;
    logic [1:0]    dir_reg, dir_next;
    logic [8:0]    path_count_reg, path_count_next;
    logic          m_valid_reg, m_valid_next;
    logic [7:0]    weight_reg, weight_next;
    logic [4:0]    rows_reg, rows_next;
    logic [4:0]    cols_reg, cols_next;

    // Payload state.
    wgac_in_t      item_reg, item_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic [AW-1:0] best_addr_reg, best_addr_next;
    node_t         best_node_reg, best_node_next;
    logic [AW-1:0] nb_addr_reg, nb_addr_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [8:0]    bld_n_reg, bld_n_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic [3:0]    res_row_reg, res_row_next;
    logic [3:0]    res_col_reg, res_col_next;
    wgac_out_t     m_data_reg, m_data_next;

    // Memory ports.
    logic           free_we, free_re, free_wdata, free_rdata;
    logic [AW-1:0]  free_waddr, free_raddr;
    logic           forb_we, forb_re;
    logic [AW-1:0]  forb_waddr, forb_raddr;
    logic [63:0]    forb_wdata, forb_rdata;
    logic           node_we, node_re;
    logic [AW-1:0]  node_waddr, node_raddr;
    logic [NW-1:0]  node_wdata, node_rdata;
    node_t          node_rd, node_new;
    logic           path_we, path_re;
    logic [PAW-1:0] path_waddr, path_raddr;
    logic [AW-1:0]  path_wdata, path_rdata;

    // Decoded values.
    logic            acc, cfg_wr, acc_cell_ok;
    logic [AW-1:0]   acc_addr, s_addr, g_addr;
    logic [6:0]      nr_lim, nc_lim;
    logic            sg_ok, nb_ok, last_dir, scan_end, relax;
    logic [RW-1:0]   cur_row, nb_row, goal_r;
    logic [CW-1:0]   cur_col, nb_col, goal_c;
    logic [9:0]      tg;
    logic            forb_hit;
    logic [HW-1:0]   h_start, h_nb;
    logic [8+HW-1:0] wh_start, wh_nb;

    function automatic logic [HW-1:0] manh(input logic [RW-1:0] ra, input logic [RW-1:0] rb,
                                           input logic [CW-1:0] ca, input logic [CW-1:0] cb);
        logic [RW-1:0] dr;
        logic [CW-1:0] dc;
        dr = (ra > rb) ? ra - rb : rb - ra;
        dc = (ca > cb) ? ca - cb : cb - ca;
        return HW'(dr) + HW'(dc);
    endfunction

    // Handshakes and configuration port.
    assign acc     = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            RegWeight: prdata = {24'd0, weight_reg};
            RegRows:   prdata = {27'd0, rows_reg};
            RegCols:   prdata = {27'd0, cols_reg};
            default:   prdata = 32'd0;
        endcase
    end

    // Address and bounds decode.
    assign acc_cell_ok = (7'(s_data.cell_row) < 7'(GRID_ROWS)) &&
                         (7'(s_data.cell_col) < 7'(GRID_COLS));
    assign acc_addr = {RW'(s_data.cell_row), CW'(s_data.cell_col)};
    assign goal_r   = RW'(item_reg.goal_row);
    assign goal_c   = CW'(item_reg.goal_col);
    assign s_addr   = {RW'(item_reg.cell_row), CW'(item_reg.cell_col)};
    assign g_addr   = {goal_r, goal_c};
    assign nr_lim   = (7'(rows_reg) < 7'(GRID_ROWS)) ? 7'(rows_reg) : 7'(GRID_ROWS);
    assign nc_lim   = (7'(cols_reg) < 7'(GRID_COLS)) ? 7'(cols_reg) : 7'(GRID_COLS);
    assign sg_ok    = (7'(item_reg.cell_row) < nr_lim) && (7'(item_reg.cell_col) < nc_lim) &&
                      (7'(item_reg.goal_row) < nr_lim) && (7'(item_reg.goal_col) < nc_lim);

    // Neighbour of the expanded cell in the current direction.
    assign cur_row = best_addr_reg[AW-1:CW];
    assign cur_col = best_addr_reg[CW-1:0];
    always_comb begin
        nb_row = cur_row;
        nb_col = cur_col;
        case (dir_reg)
            DirUp: begin
                nb_ok  = (cur_row != '0);
                nb_row = cur_row - 1'b1;
            end
            DirDown: begin
                nb_ok  = (7'(cur_row) + 7'd1 < nr_lim);
                nb_row = cur_row + 1'b1;
            end
            DirLeft: begin
                nb_ok  = (cur_col != '0);
                nb_col = cur_col - 1'b1;
            end
            default: begin
                nb_ok  = (7'(cur_col) + 7'd1 < nc_lim);
                nb_col = cur_col + 1'b1;
            end
        endcase
    end
    assign last_dir = (dir_reg == DirRight);
    assign scan_end = cnt_reg[AW] && !pend_reg;

    // Relaxation of the neighbour read back from memory.
    assign node_rd  = node_t'(node_rdata);
    assign tg       = {1'b0, best_node_reg.cost} + 10'd1;
    assign forb_hit = (tg < 10'(TimeHorizon)) && forb_rdata[tg[5:0]];
    assign relax    = free_rdata && (tg < {1'b0, node_rd.cost}) && !forb_hit;
    assign h_start  = manh(RW'(item_reg.cell_row), goal_r, CW'(item_reg.cell_col), goal_c);
    assign h_nb     = manh(nb_addr_reg[AW-1:CW], goal_r, nb_addr_reg[CW-1:0], goal_c);
    assign wh_start = weight_reg * h_start;
    assign wh_nb    = weight_reg * h_nb;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLR: begin
                if (cnt_reg[AW-1:0] == AW'(DEPTH - 1)) begin
                    state_next = boot_reg ? ST_IDLE : ST_OUT;
                end
            end
            ST_IDLE: begin
                if (acc) begin
                    case (s_data.func)
                        FuncAddCon: begin
                            state_next = (acc_cell_ok && (7'(s_data.time_step) <
                                          7'(TimeHorizon))) ? ST_CON_WR : ST_OUT;
                        end
                        FuncClrCon:   state_next = ST_CLR;
                        FuncSearch:   state_next = ST_INIT;
                        FuncReadStep: begin
                            state_next = ({1'b0, s_data.step_index} < path_count_reg) ?
                                         ST_RD_W : ST_OUT;
                        end
                        default:      state_next = ST_OUT;
                    endcase
                end
            end
            ST_CON_WR: state_next = ST_OUT;
            ST_INIT: begin
                if (cnt_reg[AW-1:0] == AW'(DEPTH - 1)) begin
                    state_next = ST_START;
                end
            end
            ST_START: state_next = sg_ok ? ST_SCAN : ST_OUT;
            ST_SCAN: begin
                if (scan_end) begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK: begin
                if (!have_reg) begin
                    state_next = ST_OUT;
                end else if (best_addr_reg == g_addr) begin
                    state_next = ST_BLD;
                end else begin
                    state_next = ST_NB_RD;
                end
            end
            ST_NB_RD: begin
                if (nb_ok) begin
                    state_next = ST_NB_EV;
                end else if (last_dir) begin
                    state_next = ST_SCAN;
                end
            end
            ST_NB_EV: state_next = last_dir ? ST_SCAN : ST_NB_RD;
            ST_BLD: begin
                if (bld_n_reg[8] || (cur_reg == s_addr)) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_BLD_W;
                end
            end
            ST_BLD_W: state_next = ST_BLD;
            ST_RD_W:  state_next = ST_OUT;
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory controls and result register.
    always_comb begin
        cnt_next        = cnt_reg;
        boot_next       = boot_reg;
        pend_next       = pend_reg;
        have_next       = have_reg;
        dir_next        = dir_reg;
        path_count_next = path_count_reg;
        item_next       = item_reg;
        rd_addr_next    = rd_addr_reg;
        best_addr_next  = best_addr_reg;
        best_node_next  = best_node_reg;
        nb_addr_next    = nb_addr_reg;
        cur_next        = cur_reg;
        bld_n_next      = bld_n_reg;
        res_status_next = res_status_reg;
        res_row_next    = res_row_reg;
        res_col_next    = res_col_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        weight_next     = weight_reg;
        rows_next       = rows_reg;
        cols_next       = cols_reg;

        free_we    = 1'b0;
        free_waddr = acc_addr;
        free_wdata = s_data.cell_free;
        free_re    = 1'b0;
        free_raddr = {nb_row, nb_col};
        forb_we    = 1'b0;
        forb_waddr = cnt_reg[AW-1:0];
        forb_wdata = 64'd0;
        forb_re    = 1'b0;
        forb_raddr = acc_addr;
        node_we    = 1'b0;
        node_waddr = cnt_reg[AW-1:0];
        node_new   = '{open: 1'b0, cost: CostNone, prio: '0, pred: '0};
        node_re    = 1'b0;
        node_raddr = cnt_reg[AW-1:0];
        path_we    = 1'b0;
        path_waddr = bld_n_reg[PAW-1:0];
        path_wdata = cur_reg;
        path_re    = 1'b0;
        path_raddr = PAW'(path_count_reg - 9'(s_data.step_index) - 9'd1);

        // Configuration writes are taken in any state.
        if (cfg_wr) begin
            case (paddr[3:2])
                RegWeight: weight_next = pwdata[7:0];
                RegRows:   rows_next   = pwdata[4:0];
                RegCols:   cols_next   = pwdata[4:0];
                default:   weight_next = weight_reg;
            endcase
        end

        case (state_reg)
            // Clearing pass over the constraint memory, and at boot over the cell memory too.
            ST_CLR: begin
                forb_we    = 1'b1;
                free_we    = boot_reg;
                free_waddr = cnt_reg[AW-1:0];
                free_wdata = 1'b0;
                cnt_next   = cnt_reg + 1'b1;
            end
            // Item decode; short functions act at once.
            ST_IDLE: begin
                if (acc) begin
                    item_next       = s_data;
                    cnt_next        = '0;
                    res_status_next = StatusDone;
                    res_row_next    = 4'd0;
                    res_col_next    = 4'd0;
                    case (s_data.func)
                        FuncWriteCell: free_we = acc_cell_ok;
                        FuncAddCon:    forb_re = 1'b1;
                        FuncClrCon:    boot_next = 1'b0;
                        FuncSearch:    path_count_next = 9'd0;
                        FuncReadStep: begin
                            path_re = 1'b1;
                            if ({1'b0, s_data.step_index} >= path_count_reg) begin
                                res_status_next = StatusBeyond;
                            end
                        end
                        default: res_status_next = StatusDone;
                    endcase
                end
            end
            ST_CON_WR: begin
                forb_we    = 1'b1;
                forb_waddr = s_addr;
                forb_wdata = forb_rdata | (64'd1 << item_reg.time_step);
            end
            // Reset every node entry before the search.
            ST_INIT: begin
                node_we  = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            ST_START: begin
                cnt_next  = '0;
                pend_next = 1'b0;
                have_next = 1'b0;
                if (sg_ok) begin
                    node_we    = 1'b1;
                    node_waddr = s_addr;
                    node_new   = '{open: 1'b1, cost: 9'd0, prio: PW'(wh_start), pred: '0};
                end else begin
                    res_status_next = StatusNoPath;
                end
            end
            // Linear scan for the open node of lowest priority.
            ST_SCAN: begin
                pend_next = !cnt_reg[AW];
                if (!cnt_reg[AW]) begin
                    node_re      = 1'b1;
                    rd_addr_next = cnt_reg[AW-1:0];
                    cnt_next     = cnt_reg + 1'b1;
                end
                if (pend_reg && node_rd.open &&
                    (!have_reg || node_rd.prio < best_node_reg.prio)) begin
                    have_next      = 1'b1;
                    best_addr_next = rd_addr_reg;
                    best_node_next = node_rd;
                end
            end
            ST_PICK: begin
                dir_next   = DirUp;
                cur_next   = g_addr;
                bld_n_next = 9'd0;
                if (!have_reg) begin
                    res_status_next = StatusNoPath;
                end else if (best_addr_reg != g_addr) begin
                    node_we       = 1'b1;
                    node_waddr    = best_addr_reg;
                    node_new      = best_node_reg;
                    node_new.open = 1'b0;
                end
            end
            ST_NB_RD: begin
                nb_addr_next = {nb_row, nb_col};
                if (nb_ok) begin
                    free_re    = 1'b1;
                    forb_re    = 1'b1;
                    forb_raddr = {nb_row, nb_col};
                    node_re    = 1'b1;
                    node_raddr = {nb_row, nb_col};
                end else begin
                    dir_next = dir_reg + 1'b1;
                    if (last_dir) begin
                        cnt_next  = '0;
                        have_next = 1'b0;
                        pend_next = 1'b0;
                    end
                end
            end
            // Relax the neighbour and start a new scan after the last direction.
            ST_NB_EV: begin
                dir_next = dir_reg + 1'b1;
                if (relax) begin
                    node_we    = 1'b1;
                    node_waddr = nb_addr_reg;
                    node_new   = '{open: 1'b1, cost: tg[8:0],
                                   prio: PW'({tg, 4'd0}) + PW'(wh_nb), pred: best_addr_reg};
                end
                if (last_dir) begin
                    cnt_next  = '0;
                    have_next = 1'b0;
                    pend_next = 1'b0;
                end
            end
            // Walk the predecessor chain back from the goal.
            ST_BLD: begin
                if (bld_n_reg[8]) begin
                    res_status_next = StatusNoPath;
                end else begin
                    path_we = 1'b1;
                    if (cur_reg == s_addr) begin
                        path_count_next = bld_n_reg + 9'd1;
                    end else begin
                        bld_n_next = bld_n_reg + 9'd1;
                        node_re    = 1'b1;
                        node_raddr = cur_reg;
                    end
                end
            end
            ST_BLD_W: cur_next = node_rd.pred;
            ST_RD_W: begin
                res_row_next = 4'(path_rdata[AW-1:CW]);
                res_col_next = 4'(path_rdata[CW-1:0]);
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{status: res_status_reg,
                                     found: (path_count_reg != 9'd0),
                                     path_length: path_count_reg,
                                     step_row: res_row_reg,
                                     step_col: res_col_reg};
                end
            end
            default: cnt_next = cnt_reg;
        endcase
        node_wdata = node_new;
    end

    // Path entries are stored goal first; a read counts back from the end.

    // Registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLR;
            cnt_reg        <= '0;
            boot_reg       <= 1'b1;
            pend_reg       <= 1'b0;
            have_reg       <= 1'b0;
            dir_reg        <= DirUp;
            path_count_reg <= 9'd0;
            m_valid_reg    <= 1'b0;
            weight_reg     <= 8'd16;
            rows_reg       <= 5'd16;
            cols_reg       <= 5'd16;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            boot_reg       <= boot_next;
            pend_reg       <= pend_next;
            have_reg       <= have_next;
            dir_reg        <= dir_next;
            path_count_reg <= path_count_next;
            m_valid_reg    <= m_valid_next;
            weight_reg     <= weight_next;
            rows_reg       <= rows_next;
            cols_reg       <= cols_next;
        end
        item_reg       <= item_next;
        rd_addr_reg    <= rd_addr_next;
        best_addr_reg  <= best_addr_next;
        best_node_reg  <= best_node_next;
        nb_addr_reg    <= nb_addr_next;
        cur_reg        <= cur_next;
        bld_n_reg      <= bld_n_next;
        res_status_reg <= res_status_next;
        res_row_reg    <= res_row_next;
        res_col_reg    <= res_col_next;
        m_data_reg     <= m_data_next;
    end

    // Memories.
    wgac_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_free_ram (
        .aclk(aclk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
        .re(free_re), .raddr(free_raddr), .rdata(free_rdata)
    );

    wgac_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_forb_ram (
        .aclk(aclk), .we(forb_we), .waddr(forb_waddr), .wdata(forb_wdata),
        .re(forb_re), .raddr(forb_raddr), .rdata(forb_rdata)
    );

    wgac_ram #(.WIDTH(NW), .DEPTH(DEPTH)) u_node_ram (
        .aclk(aclk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
        .re(node_re), .raddr(node_raddr), .rdata(node_rdata)
    );

    wgac_ram #(.WIDTH(AW), .DEPTH(PathLimit)) u_path_ram (
        .aclk(aclk), .we(path_we), .waddr(path_waddr), .wdata(path_wdata),
        .re(path_re), .raddr(path_raddr), .rdata(path_rdata)
    );

    // Checks.
    `WGAC_ASSERT_IMPL(a_found_len, m_valid, m_data.found == (m_data.path_length != 9'd0), "found flag disagrees with path length")
    `WGAC_ASSERT_IMPL(a_beyond_zero, m_valid && (m_data.status == StatusBeyond), (m_data.step_row == 4'd0) && (m_data.step_col == 4'd0), "step fields set on out of range read")
    `WGAC_ASSERT_IMPL(a_node_port, node_we && node_re, node_waddr != node_raddr, "node memory read and write collide")
    `WGAC_ASSERT_ALWAYS(a_path_cap, path_count_reg <= 9'(PathLimit), "path count above limit")

endmodule

// ----- rtl/core/wgac_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module wgac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
